// ===== rtl/wavetable_oscillator_assert.svh =====
// Assertion macros for the wavetable oscillator back end.
`ifndef WAVETABLE_OSCILLATOR_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define WO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define WO_NEVER(lbl, cond, msg) \
  `WO_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/wo_pkg.sv =====
// Shared types and constants for the wavetable oscillator.
package wo_pkg;

  localparam int IdxBits    = 10;
  localparam int FracBits   = 16;
  localparam int SampleBits = 16;
  localparam int PhaseBits  = IdxBits + FracBits;
  localparam int AmpBits    = 16;
  localparam int CfgIdxBits = 2;
  localparam int CfgBits    = PhaseBits;
  localparam int TableSize  = 1 << IdxBits;
  localparam int QueueDepth = 2;
  localparam int QPtrBits   = $clog2(QueueDepth);
  localparam int QCntBits   = $clog2(QueueDepth + 1);
  localparam int InDataBits = 32;

  localparam logic [CfgIdxBits-1:0] RegPhaseInc  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegAmplitude = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegInterp    = 2'd2;

  localparam logic [PhaseBits-1:0] PhaseIncReset = '0;
  localparam logic [AmpBits-1:0]   AmpReset      = 16'd32768;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLEND,
    ST_SCALE,
    ST_SAT
  } back_state_e;

  typedef struct packed {
    op_e                   op;
    logic [IdxBits-1:0]    addr;
    logic [FracBits-1:0]   frac;
    logic [SampleBits-1:0] value;
  } cmd_t;

endpackage

// ===== rtl/wo_front.sv =====
// Front end: accepts items, runs the phase accumulator, emits commands.
module wo_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_op_i,
  input  logic                          in_restart_i,
  input  logic [wo_pkg::IdxBits-1:0]    in_index_i,
  input  logic [wo_pkg::SampleBits-1:0] in_value_i,
  input  logic [wo_pkg::PhaseBits-1:0]  phase_inc_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output wo_pkg::cmd_t                  cmd_o
);
  import wo_pkg::*;

  logic [PhaseBits-1:0] phase_q, phase_d, phase_cur;
  logic                 take;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign take        = in_valid_i && cmd_ready_i;
  assign phase_cur   = in_restart_i ? '0 : phase_q;

  always_comb begin
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.op = op_e'(in_op_i);
    if (op_e'(in_op_i) == OP_TICK) begin
      cmd_o.addr = phase_cur[PhaseBits-1:FracBits];
      cmd_o.frac = phase_cur[FracBits-1:0];
      if (take) begin
        phase_d = phase_cur + phase_inc_i;
      end
    end else begin
      cmd_o.addr  = in_index_i;
      cmd_o.value = in_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/wo_queue.sv =====
// Two-entry command queue between front and back.
module wo_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  wo_pkg::cmd_t push_cmd_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output wo_pkg::cmd_t pop_cmd_o
);
  import wo_pkg::*;

  cmd_t                mem_q [QueueDepth];
  logic [QPtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntBits-1:0] cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != QCntBits'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCntBits'(push) - QCntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/wo_back.sv =====
// Back end: wave table, interpolation, gain, saturation and output register.
module wo_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  wo_pkg::cmd_t                  cmd_i,
  input  logic [wo_pkg::AmpBits-1:0]    amplitude_i,
  input  logic                          interp_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wo_pkg::SampleBits-1:0] out_sample_o
);
  import wo_pkg::*;

  localparam int ProdBits  = SampleBits + 1 + FracBits + 1;
  localparam int GainBits  = SampleBits + AmpBits + 1;
  localparam int ScaleBits = GainBits - 15;

  localparam logic signed [ScaleBits-1:0] SatMax = ScaleBits'((1 << (SampleBits - 1)) - 1);
  localparam logic signed [ScaleBits-1:0] SatMin = -SatMax - ScaleBits'(1);

  logic [SampleBits-1:0] table_q [TableSize];

  back_state_e state_q, state_d;
  logic        pop;
  logic        out_load;

  logic signed [SampleBits-1:0] y0_q, y1_q, blend_q;
  logic [FracBits-1:0]          frac_q;
  logic signed [ScaleBits-1:0]  scaled_q;
  logic [SampleBits-1:0]        out_q;
  logic                         out_valid_q;

  logic signed [SampleBits:0]    diff;
  logic signed [ProdBits-1:0]    blend_prod;
  logic signed [SampleBits+1:0]  blend_sum;
  logic signed [GainBits-1:0]    gain_prod;
  logic [SampleBits-1:0]         sat_val;

  assign cmd_ready_o  = (state_q == ST_IDLE);
  assign pop          = cmd_valid_i && cmd_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pop && cmd_i.op == OP_TICK) begin
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: state_d = ST_SCALE;
      ST_SCALE: state_d = ST_SAT;
      ST_SAT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    diff       = {y1_q[SampleBits-1], y1_q} - {y0_q[SampleBits-1], y0_q};
    blend_prod = ProdBits'(diff) * ProdBits'(signed'({1'b0, frac_q}));
    blend_sum  = (SampleBits+2)'(y0_q) + (SampleBits+2)'(blend_prod >>> FracBits);
    gain_prod  = GainBits'(blend_q) * GainBits'(signed'({1'b0, amplitude_i}));
    if (scaled_q > SatMax) begin
      sat_val = SatMax[SampleBits-1:0];
    end else if (scaled_q < SatMin) begin
      sat_val = SatMin[SampleBits-1:0];
    end else begin
      sat_val = scaled_q[SampleBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // table port: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.op == OP_WRITE) begin
      table_q[cmd_i.addr] <= cmd_i.value;
    end
    if (pop && cmd_i.op == OP_TICK) begin
      y0_q   <= signed'(table_q[cmd_i.addr]);
      y1_q   <= signed'(table_q[cmd_i.addr + 1'b1]);
      frac_q <= cmd_i.frac;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_BLEND) begin
      blend_q <= interp_i ? blend_sum[SampleBits-1:0] : y0_q;
    end
    if (state_q == ST_SCALE) begin
      scaled_q <= gain_prod[GainBits-1:15];
    end
    if (out_load) begin
      out_q <= sat_val;
    end
  end

  `include "wavetable_oscillator_assert.svh"

  `WO_ASSERT(a_tick_starts, (pop && cmd_i.op == OP_TICK) |=> (state_q == ST_BLEND), "tick did not start blend")
  `WO_ASSERT(a_blend_scale, (state_q == ST_BLEND) |=> (state_q == ST_SCALE), "blend not followed by scale")
  `WO_ASSERT(a_sat_loads, (state_q == ST_SAT && (!out_valid_q || out_ready_i)) |=> (out_valid_q && state_q == ST_IDLE), "result not loaded")
  `WO_NEVER(a_no_busy_pop, (pop && state_q != ST_IDLE), "command taken while busy")

endmodule

// ===== rtl/wavetable_oscillator.sv =====
// Top level of the wavetable oscillator: config registers, front, queue and back.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser: operation; tdata: restart, index, value
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: sample
//  cfg       in   cfg_we_i                      cfg_idx_i, cfg_data_i
//
// Write items do not hold the back sequencer; the queue accepts one item per cycle
// while not full. A tick holds the sequencer through table read, blend multiply,
// gain multiply and saturate into the output register before it takes a new command.
// Reset clears the phase and loads register defaults; table contents are undefined.
// A stalled output holds the sequencer in its last step; the queue then fills and
// s_axis_tready drops.
module wavetable_oscillator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [wo_pkg::InDataBits-1:0] s_axis_tdata,  // restart, table_index, table_value
  input  logic                          s_axis_tuser,  // operation
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [wo_pkg::SampleBits-1:0] m_axis_tdata,  // sample
  input  logic                          cfg_we_i,
  input  logic [wo_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [wo_pkg::CfgBits-1:0]    cfg_data_i
);
  import wo_pkg::*;

  logic [PhaseBits-1:0] phase_inc_q;
  logic [AmpBits-1:0]   amplitude_q;
  logic                 interp_q;

  logic cmd_valid, cmd_ready, q_valid, q_ready;
  cmd_t cmd, q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= PhaseIncReset;
      amplitude_q <= AmpReset;
      interp_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPhaseInc:  phase_inc_q <= cfg_data_i;
        RegAmplitude: amplitude_q <= cfg_data_i[AmpBits-1:0];
        RegInterp:    interp_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  wo_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_restart_i (s_axis_tdata[0]),
    .in_index_i   (s_axis_tdata[IdxBits:1]),
    .in_value_i   (s_axis_tdata[IdxBits+SampleBits:IdxBits+1]),
    .phase_inc_i  (phase_inc_q),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  wo_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_cmd_i   (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  wo_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_ready_o  (q_ready),
    .cmd_i        (q_cmd),
    .amplitude_i  (amplitude_q),
    .interp_i     (interp_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (m_axis_tdata)
  );

endmodule

// ===== bench/wavetable_oscillator_test.sv =====
// Self-checking testbench for the wavetable oscillator: table loads, ticks, gain and blend modes.
module wavetable_oscillator_test;
  import wo_pkg::*;

  localparam logic [CfgIdxBits-1:0] RegUnused = 2'd3;
  localparam int unsigned RndVal = 32'hFFFF_FFFF;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 16;
  localparam int CycleLimit = 400000;
  localparam longint SampMax = (64'sd1 <<< (SampleBits - 1)) - 1;
  localparam longint SampMin = -SampMax - 1;

  typedef struct packed {
    op_e                          op;
    logic                         restart;
    logic [IdxBits-1:0]           index;
    logic signed [SampleBits-1:0] value;
  } osc_item_t;

  typedef struct {
    bit                    is_cfg;
    logic [CfgIdxBits-1:0] reg_idx;
    logic [CfgBits-1:0]    cfg_val;
    osc_item_t             it;
    bit                    chk;
    logic [SampleBits-1:0] want;
  } stim_row_t;

  typedef struct {
    int unsigned inc;
    int unsigned amp;
    int unsigned interp;
    int          src_pct;
    int          snk_pct;
    int          n_items;
    bit          hold;
    bit          pause;
  } osc_phase_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataBits-1:0]   s_axis_tdata = '0;  // restart, table_index, table_value
  logic                    s_axis_tuser = 1'b0;  // operation
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [SampleBits-1:0]   m_axis_tdata;  // sample
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]   cfg_idx_i = '0;
  logic [CfgBits-1:0]      cfg_data_i = '0;

  // predictor state
  logic signed [SampleBits-1:0] wave_mem [TableSize];
  logic [PhaseBits-1:0]         phase_acc;
  logic [PhaseBits-1:0]         inc_q;
  logic [AmpBits-1:0]           gain_q;
  logic                         interp_q;
  logic [SampleBits-1:0]        sample_q [$];

  int err_cnt = 0;
  int cyc_cnt = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit hold_req = 1'b0;
  logic [SampleBits-1:0] want_s;

  stim_row_t dir_rows [$];

  osc_phase_t phases [8] = '{
    '{32'h0001_0000, 32768,  1,      0,  0,  75, 1'b0, 1'b0},
    '{32'h0002_A3F1, 16384,  0,      65, 0,  75, 1'b0, 1'b0},
    '{32'h03FF_FFFF, 65535,  1,      0,  65, 75, 1'b1, 1'b0},
    '{32'h0000_0000, 0,      1,      23, 23, 75, 1'b0, 1'b0},
    '{RndVal,        RndVal, 0,      0,  0,  75, 1'b0, 1'b0},
    '{RndVal,        32768,  1,      0,  65, 75, 1'b0, 1'b1},
    '{32'h0000_0001, 32767,  1,      65, 0,  75, 1'b0, 1'b0},
    '{RndVal,        RndVal, RndVal, 23, 23, 75, 1'b0, 1'b0}
  };

  wavetable_oscillator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit osc_model(input osc_item_t it, output logic [SampleBits-1:0] smp);
    logic [IdxBits-1:0] ix;
    logic [IdxBits-1:0] ix_nx;
    longint y0, y1, y, s;
    smp = '0;
    if (it.op == OP_WRITE) begin
      wave_mem[it.index] = it.value;
      return 1'b0;
    end
    if (it.restart) phase_acc = '0;
    ix = phase_acc[PhaseBits-1:FracBits];
    ix_nx = ix + 1'b1;
    y0 = longint'(wave_mem[ix]);
    y = y0;
    if (interp_q) begin
      y1 = longint'(wave_mem[ix_nx]);
      y = y0 + (((y1 - y0) * longint'(phase_acc[FracBits-1:0])) >>> FracBits);
    end
    s = (y * longint'(gain_q)) >>> 15;
    if (s > SampMax) s = SampMax;
    else if (s < SampMin) s = SampMin;
    smp = s[SampleBits-1:0];
    phase_acc = phase_acc + inc_q;
    return 1'b1;
  endfunction

  function automatic stim_row_t item_row(input op_e op, input logic rs,
                                         input logic [IdxBits-1:0] ix,
                                         input logic signed [SampleBits-1:0] v,
                                         input bit chk, input logic [SampleBits-1:0] want);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = '0;
    r.cfg_val = '0;
    r.it.op = op;
    r.it.restart = rs;
    r.it.index = ix;
    r.it.value = v;
    r.chk = chk;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CfgIdxBits-1:0] ri,
                                        input logic [CfgBits-1:0] cv);
    stim_row_t r;
    r = item_row(OP_TICK, 1'b0, '0, '0, 1'b0, '0);
    r.is_cfg = 1'b1;
    r.reg_idx = ri;
    r.cfg_val = cv;
    return r;
  endfunction

  function automatic logic signed [SampleBits-1:0] rand_value();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return SampleBits'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [SampleBits-1:0] got,
                                 input logic [SampleBits-1:0] want);
    $display("mismatch: %s got %0d expected %0d", what, $signed(got), $signed(want));
    err_cnt++;
  endtask

  // called and returns at a falling edge
  task automatic send_item(input osc_item_t it, input bit chk,
                           input logic [SampleBits-1:0] want);
    logic [SampleBits-1:0] smp;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {5'd0, it.value, it.index, it.restart};
    do @(posedge clk_i); while (!s_axis_tready);
    if (osc_model(it, smp)) sample_q = {sample_q, (chk ? want : smp)};
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sample_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] ri, input logic [CfgBits-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ri;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (ri)
      RegPhaseInc:  inc_q = val;
      RegAmplitude: gain_q = val[AmpBits-1:0];
      RegInterp:    interp_q = val[0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sample_q.size() == 0) begin
        report_mismatch("sample with no tick pending", m_axis_tdata, '0);
      end else begin
        want_s = sample_q.pop_front();
        if (m_axis_tdata !== want_s) report_mismatch("sample", m_axis_tdata, want_s);
      end
    end
  end

  initial begin : sink
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin : watchdog
    while (cyc_cnt < CycleLimit) begin
      @(posedge clk_i);
      cyc_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    osc_item_t   it;
    osc_phase_t  ph;
    int unsigned inc_v, amp_v, mode_v;

    phase_acc = '0;
    inc_q     = PhaseIncReset;
    gain_q    = AmpReset;
    interp_q  = 1'b1;

    dir_rows = '{
      item_row(OP_WRITE, 1'b0, 10'd0, 16'sh7FFF, 1'b0, '0),
      item_row(OP_WRITE, 1'b1, 10'd1, 16'sh8000, 1'b0, '0),  // restart ignored on a write
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b1, 16'h7FFF),
      cfg_row(RegAmplitude, 26'd0),
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b1, 16'h0000),
      cfg_row(RegAmplitude, 26'd65535),  // gain above unity
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b1, 16'h7FFF),
      item_row(OP_WRITE, 1'b0, 10'd0, 16'sh8000, 1'b0, '0),
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b1, 16'h8000),
      cfg_row(RegInterp, 26'd0),
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b1, 16'h8000),
      cfg_row(RegAmplitude, 26'd32768),
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b1, 16'h8000),
      cfg_row(RegUnused, 26'h3FF_FFFF),  // no register at this index
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b1, 16'h8000),
      cfg_row(RegInterp, 26'd1),
      cfg_row(RegPhaseInc, 26'h8000),
      item_row(OP_WRITE, 1'b0, 10'd0, 16'sd0, 1'b0, '0),
      item_row(OP_WRITE, 1'b0, 10'd1, 16'sd1000, 1'b0, '0),
      item_row(OP_WRITE, 1'b1, 10'd2, 16'sd3000, 1'b0, '0),
      item_row(OP_WRITE, 1'b0, 10'd3, 16'sd0, 1'b0, '0),
      item_row(OP_TICK,  1'b1, 10'd0, 16'sd0, 1'b1, 16'd0),
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b1, 16'd500),
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b1, 16'd1000),
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b1, 16'd2000),
      item_row(OP_WRITE, 1'b0, 10'd0, 16'sd1, 1'b0, '0),
      item_row(OP_WRITE, 1'b0, 10'd1, 16'sd0, 1'b0, '0),
      item_row(OP_TICK,  1'b1, 10'd0, 16'sd0, 1'b0, '0),
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b0, '0),  // falling slope rounds down
      cfg_row(RegPhaseInc, 26'h3FF_FFFF),
      item_row(OP_WRITE, 1'b0, 10'd1023, 16'sh7FFF, 1'b0, '0),
      item_row(OP_WRITE, 1'b0, 10'd0, 16'sh8000, 1'b0, '0),
      item_row(OP_TICK,  1'b1, 10'd0, 16'sd0, 1'b0, '0),
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b0, '0),  // next index wraps to zero
      item_row(OP_TICK,  1'b0, 10'd0, 16'sd0, 1'b0, '0)
    };

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        wait_idle();
        write_reg(dir_rows[k].reg_idx, dir_rows[k].cfg_val);
      end else begin
        send_item(dir_rows[k].it, dir_rows[k].chk, dir_rows[k].want);
      end
    end

    // fill the whole table so any phase reads written entries
    for (int i = 0; i < TableSize; i++) begin
      it.op = OP_WRITE;
      it.restart = 1'($urandom_range(1));
      it.index = IdxBits'(i);
      it.value = rand_value();
      send_item(it, 1'b0, '0);
    end

    foreach (phases[p]) begin
      ph = phases[p];
      wait_idle();
      inc_v  = (ph.inc == RndVal) ? $urandom_range(32'h03FF_FFFF) : ph.inc;
      amp_v  = (ph.amp == RndVal) ? $urandom_range(65535) : ph.amp;
      mode_v = (ph.interp == RndVal) ? $urandom_range(1) : ph.interp;
      write_reg(RegPhaseInc, inc_v[CfgBits-1:0]);
      write_reg(RegAmplitude, amp_v[CfgBits-1:0]);
      write_reg(RegInterp, mode_v[CfgBits-1:0]);
      src_idle_pct  = ph.src_pct;
      snk_stall_pct = ph.snk_pct;
      for (int n = 0; n < ph.n_items; n++) begin
        if (ph.hold && n == 20) hold_req = 1'b1;
        if (ph.pause && n == ph.n_items / 2) wait_idle();
        it.op = ($urandom_range(99) < 70) ? OP_TICK : OP_WRITE;
        it.restart = ($urandom_range(99) < ((it.op == OP_TICK) ? 4 : 40));
        it.index = IdxBits'($urandom_range(TableSize - 1));
        it.value = rand_value();
        send_item(it, 1'b0, '0);
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== wavetable_oscillator.f =====
+incdir+rtl
rtl/wo_pkg.sv
rtl/wo_front.sv
rtl/wo_queue.sv
rtl/wo_back.sv
rtl/wavetable_oscillator.sv
bench/wavetable_oscillator_test.sv
